@@ rtl/ambient_light_lux_calc_macros.svh @@
// Assertion macros shared by the lux calculation RTL.
`ifndef AMBIENT_LIGHT_LUX_CALC_MACROS_SVH
`define AMBIENT_LIGHT_LUX_CALC_MACROS_SVH

`ifndef SYNTH
`define ALC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ALC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`define ALC_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");
`else
`define ALC_ASSERT_IMP(lbl, ante, cons)
`define ALC_ASSERT_NXT(lbl, ante, cons)
`define ALC_ASSERT_DLY(lbl, ante, dly, cons)
`endif

`endif

@@ rtl/alc_pkg.sv @@
// Package: widths, constants, register codes and the denominator function of the lux block.
package alc_pkg;

  localparam int COUNT_BITS     = 16;
  localparam int COEF_FRAC_BITS = 10;
  localparam int GA_FRAC_BITS   = 8;
  localparam int GA_W           = 16;
  localparam int LUX_W          = 32;
  localparam int LF_W           = 20;
  localparam int DEN_W          = 30;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;

  localparam int COEF_A_INT = ((187 << COEF_FRAC_BITS) + 50) / 100;
  localparam int COEF_B_INT = ((63 << COEF_FRAC_BITS) + 50) / 100;

  localparam int S_W        = COUNT_BITS + COEF_FRAC_BITS + 2;
  localparam int M_W        = COUNT_BITS + COEF_FRAC_BITS;
  localparam int P_W        = M_W + GA_W;
  localparam int P_LO       = P_W / 2;
  localparam int P_HI       = P_W - P_LO;
  localparam int N_W        = P_W + LF_W;
  localparam int NH_W       = N_W - LUX_W;
  localparam int SH         = COEF_FRAC_BITS + GA_FRAC_BITS;
  localparam int DS_W       = DEN_W + SH;
  localparam int R_W        = DS_W + 1;
  localparam int DIV_STAGES = LUX_W;
  localparam int LATENCY    = 7 + DIV_STAGES;

  localparam logic [S_W-1:0]  COEF_A     = S_W'(COEF_A_INT);
  localparam logic [S_W-1:0]  COEF_B     = S_W'(COEF_B_INT);
  localparam logic [LF_W-1:0] LUX_FACTOR = LF_W'(600000);
  localparam logic [GA_W-1:0] GA_RESET   = GA_W'(256);

  typedef enum logic [1:0] {
    REG_TIME  = 2'd0,
    REG_GAIN  = 2'd1,
    REG_SCALE = 2'd2,
    REG_GLASS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic sat;
  } div_ctl_t;

  // time in 0.01 ms times gain times scale (16 for the 0.16 scale, else 100)
  function automatic logic [DEN_W-1:0] den_of(input logic [2:0] ts, input logic [1:0] gs,
                                               input logic sc);
    logic [DEN_W-1:0] t;
    logic [DEN_W-1:0] g;
    logic [DEN_W-1:0] s;
    case (ts)
      3'd0:    t = DEN_W'(273);
      3'd1:    t = DEN_W'(2733);
      3'd2:    t = DEN_W'(10100);
      3'd3:    t = DEN_W'(17500);
      default: t = DEN_W'(60000);
    endcase
    case (gs)
      2'd0:    g = DEN_W'(1);
      2'd1:    g = DEN_W'(8);
      2'd2:    g = DEN_W'(16);
      default: g = DEN_W'(120);
    endcase
    s = sc ? DEN_W'(16) : DEN_W'(100);
    return t * g * s;
  endfunction

endpackage

@@ rtl/ambient_light_lux_calc.sv @@
// Top level: lux from a broadband/infrared count pair, fully pipelined.
//
// Usage:
//   Drive ch0_count_i / ch1_count_i and raise start_i for one cycle per word.
//   busy_o stays low: a new pair is taken at every rising edge with start_i high.
//   Each result appears on lux_o / saturated_o for exactly one cycle, marked by
//   done_o, once the pair has passed the front stages, the divider and the
//   output register. Results come out in order, one per accepted pair, at up to
//   one per cycle.
//   The datapath is six front stages (capture, numerators, attenuation multiply,
//   two-step constant multiply, saturation compare), a 32-stage restoring
//   divider producing one quotient bit per stage and an output register.
//   Saturation (lux_o = all ones, saturated_o = 1) is flagged when the quotient
//   does not fit 32 bits.
//   Configuration sits on an APB-style port at byte addresses 0, 4, 8, 12
//   (time select, gain select, gain scale, glass attenuation); write it only
//   while no result is outstanding. pready is always high.
//   Reset clears all valid bits and loads the default configuration.
//   There is no backpressure: the receiver must take each result when shown.
`include "ambient_light_lux_calc_macros.svh"

module ambient_light_lux_calc
  import alc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [COUNT_BITS-1:0] ch0_count_i,
  input  logic [COUNT_BITS-1:0] ch1_count_i,
  output logic                  done_o,
  output logic [LUX_W-1:0]      lux_o,
  output logic                  saturated_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  logic [2:0]      time_sel_q;
  logic [1:0]      gain_sel_q;
  logic            scale_on_q;
  logic [GA_W-1:0] glass_q;
  logic [DS_W-1:0] den_d;
  logic [DS_W-1:0] den_q;
  logic            cfg_wr;
  cfg_reg_e        cfg_reg;

  logic                  in_acc;
  logic                  in_v_q;
  logic [COUNT_BITS-1:0] ch0_q;
  logic [COUNT_BITS-1:0] ch1_q;

  logic [S_W-1:0] a_ext;
  logic [S_W-1:0] b_ext;
  logic [S_W-1:0] n1;
  logic [S_W-1:0] n2;
  logic [S_W-1:0] n_max;
  logic [M_W-1:0] m_d;
  logic           m_v_q;
  logic [M_W-1:0] m_q;

  logic           p_v_q;
  logic [P_W-1:0] p_q;

  logic                pp_v_q;
  logic [P_LO+LF_W-1:0] pl_q;
  logic [P_HI+LF_W-1:0] ph_q;

  logic           n_v_q;
  logic [N_W-1:0] n_d;
  logic [N_W-1:0] n_q;

  logic [R_W-1:0]   nh_ext;
  div_ctl_t         div_ctl_d;
  div_ctl_t         div_ctl_q;
  logic [R_W-1:0]   rem0_q;
  logic [LUX_W-1:0] lo0_q;
  div_ctl_t         out_ctl;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_reg = cfg_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_sel_q <= '0;
      gain_sel_q <= '0;
      scale_on_q <= 1'b0;
      glass_q    <= GA_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_TIME:  time_sel_q <= pwdata[2:0];
        REG_GAIN:  gain_sel_q <= pwdata[1:0];
        REG_SCALE: scale_on_q <= pwdata[0];
        REG_GLASS: glass_q    <= pwdata[GA_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_TIME:  prdata = {{(DATA_W-3){1'b0}}, time_sel_q};
      REG_GAIN:  prdata = {{(DATA_W-2){1'b0}}, gain_sel_q};
      REG_SCALE: prdata = {{(DATA_W-1){1'b0}}, scale_on_q};
      REG_GLASS: prdata = {{(DATA_W-GA_W){1'b0}}, glass_q};
    endcase
  end

  // divisor scaled by the fraction bits of the numerator
  assign den_d = {den_of(time_sel_q, gain_sel_q, scale_on_q), {SH{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q <= '0;
    end else begin
      den_q <= den_d;
    end
  end

  // input capture
  assign busy_o = 1'b0;
  assign in_acc = start_i & ~busy_o;

  always_ff @(posedge clk_i) begin
    ch0_q <= ch0_count_i;
    ch1_q <= ch1_count_i;
  end

  // numerators; a non-positive first numerator yields zero through the chain
  assign a_ext = {{(S_W-COUNT_BITS){1'b0}}, ch0_q};
  assign b_ext = {{(S_W-COUNT_BITS){1'b0}}, ch1_q};
  assign n1    = (a_ext << COEF_FRAC_BITS) - COEF_A * b_ext;
  assign n2    = COEF_B * a_ext - (b_ext << COEF_FRAC_BITS);
  assign n_max = ($signed(n1) >= $signed(n2)) ? n1 : n2;

  always_comb begin
    if (n1[S_W-1] || (n1 == '0)) begin
      m_d = '0;
    end else begin
      m_d = n_max[M_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    m_q  <= m_d;
    p_q  <= {{GA_W{1'b0}}, m_q} * {{M_W{1'b0}}, glass_q};
    pl_q <= {{LF_W{1'b0}}, p_q[P_LO-1:0]} * {{P_LO{1'b0}}, LUX_FACTOR};
    ph_q <= {{LF_W{1'b0}}, p_q[P_W-1:P_LO]} * {{P_HI{1'b0}}, LUX_FACTOR};
    n_q  <= n_d;
  end

  assign n_d = {{(N_W-P_LO-LF_W){1'b0}}, pl_q} + {ph_q, {P_LO{1'b0}}};

  // the quotient fits 32 bits only while the upper numerator part is below the divisor
  assign nh_ext          = {{(R_W-NH_W){1'b0}}, n_q[N_W-1:LUX_W]};
  assign div_ctl_d.valid = n_v_q;
  assign div_ctl_d.sat   = nh_ext >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    rem0_q <= nh_ext;
    lo0_q  <= n_q[LUX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      m_v_q     <= 1'b0;
      p_v_q     <= 1'b0;
      pp_v_q    <= 1'b0;
      n_v_q     <= 1'b0;
      div_ctl_q <= '0;
    end else begin
      in_v_q    <= in_acc;
      m_v_q     <= in_v_q;
      p_v_q     <= m_v_q;
      pp_v_q    <= p_v_q;
      n_v_q     <= pp_v_q;
      div_ctl_q <= div_ctl_d;
    end
  end

  alc_div_pipe u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_ctl_q),
    .rem_i    (rem0_q),
    .num_lo_i (lo0_q),
    .den_i    (den_q),
    .ctl_o    (out_ctl),
    .lux_o    (lux_o)
  );

  assign done_o      = out_ctl.valid;
  assign saturated_o = out_ctl.sat;

  `ALC_ASSERT_DLY(a_latency, in_acc, LATENCY, done_o)
  `ALC_ASSERT_DLY(a_dark_zero, in_acc && (ch0_count_i == '0), LATENCY,
                  done_o && (lux_o == '0) && !saturated_o)
  `ALC_ASSERT_NXT(a_ir_dominant_zero, in_v_q && (ch0_q <= ch1_q), m_q == '0)

endmodule

@@ rtl/alc_div_pipe.sv @@
// Restoring divider pipeline, one quotient bit per stage, with saturating output register.
`include "ambient_light_lux_calc_macros.svh"

module alc_div_pipe
  import alc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_ctl_t         ctl_i,
  input  logic [R_W-1:0]   rem_i,
  input  logic [LUX_W-1:0] num_lo_i,
  input  logic [DS_W-1:0]  den_i,
  output div_ctl_t         ctl_o,
  output logic [LUX_W-1:0] lux_o
);

  logic [R_W-1:0]   den_ext;
  logic [R_W-1:0]   prev_rem [DIV_STAGES];
  logic [LUX_W-1:0] prev_lo  [DIV_STAGES];
  logic [LUX_W-1:0] prev_quo [DIV_STAGES];
  div_ctl_t         prev_ctl [DIV_STAGES];
  logic [R_W-1:0]   rem_d    [DIV_STAGES];
  logic [LUX_W-1:0] lo_d     [DIV_STAGES];
  logic [LUX_W-1:0] quo_d    [DIV_STAGES];
  logic [R_W-1:0]   rem_q    [DIV_STAGES];
  logic [LUX_W-1:0] lo_q     [DIV_STAGES];
  logic [LUX_W-1:0] quo_q    [DIV_STAGES];
  div_ctl_t         ctl_q    [DIV_STAGES];
  div_ctl_t         out_ctl_q;
  logic [LUX_W-1:0] lux_d;
  logic [LUX_W-1:0] lux_q;
  logic [R_W-1:0]   trial;

  assign den_ext = {1'b0, den_i};

  always_comb begin
    prev_rem[0] = rem_i;
    prev_lo[0]  = num_lo_i;
    prev_quo[0] = '0;
    prev_ctl[0] = ctl_i;
    for (int k = 1; k < DIV_STAGES; k++) begin
      prev_rem[k] = rem_q[k-1];
      prev_lo[k]  = lo_q[k-1];
      prev_quo[k] = quo_q[k-1];
      prev_ctl[k] = ctl_q[k-1];
    end
  end

  // shift in the next numerator bit, subtract the divisor when it fits
  always_comb begin
    trial = '0;
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial = {prev_rem[k][R_W-2:0], prev_lo[k][LUX_W-1]};
      if (trial >= den_ext) begin
        rem_d[k] = trial - den_ext;
        quo_d[k] = {prev_quo[k][LUX_W-2:0], 1'b1};
      end else begin
        rem_d[k] = trial;
        quo_d[k] = {prev_quo[k][LUX_W-2:0], 1'b0};
      end
      lo_d[k] = {prev_lo[k][LUX_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      rem_q[k] <= rem_d[k];
      lo_q[k]  <= lo_d[k];
      quo_q[k] <= quo_d[k];
    end
    lux_q <= lux_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        ctl_q[k] <= '0;
      end
      out_ctl_q <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        ctl_q[k] <= prev_ctl[k];
      end
      out_ctl_q <= ctl_q[DIV_STAGES-1];
    end
  end

  assign lux_d = ctl_q[DIV_STAGES-1].sat ? '1 : quo_q[DIV_STAGES-1];
  assign ctl_o = out_ctl_q;
  assign lux_o = lux_q;

  `ALC_ASSERT_IMP(a_init_rem_lt_den, ctl_i.valid && !ctl_i.sat, rem_i < den_ext)
  `ALC_ASSERT_IMP(a_last_rem_lt_den, ctl_q[DIV_STAGES-1].valid && !ctl_q[DIV_STAGES-1].sat,
                  rem_q[DIV_STAGES-1] < den_ext)
  `ALC_ASSERT_IMP(a_sat_is_max, out_ctl_q.valid && out_ctl_q.sat, lux_q == '1)

endmodule
